// ===== rtl/paik_pkg.sv =====
package paik_pkg;

    // Field and register widths
    localparam int COORD_W    = 18;
    localparam int ZR_W       = COORD_W + 1;
    localparam int ANG_W      = 16;
    localparam int ELEV_W     = ANG_W - 1;
    localparam int RAD_W      = COORD_W - 1;
    localparam int CH_W       = 13;
    localparam int RMIN_W     = 13;
    localparam int RMAX_W     = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RHO_MIN       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RHO_MAX       = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NEAR = 2'd1;
    localparam logic [1:0] ST_FAR  = 2'd2;
    localparam logic [1:0] ST_ELEV = 2'd3;

    // Products and sums of squares
    localparam int SQP_W = 2 * COORD_W;
    localparam int ZZP_W = 2 * ZR_W;
    localparam int SXY_W = SQP_W + 1;
    localparam int S_W   = ZZP_W + 1;
    localparam int RMIN2_W = 2 * RMIN_W;
    localparam int RMAX2_W = 2 * RMAX_W;

    // Square root unit: one result bit per stage
    localparam int SQ_W      = 40;
    localparam int SQ_STEPS  = 19;
    localparam int SQ_TOP    = 2 * (SQ_STEPS - 1);
    localparam int ROOT_W    = SQ_STEPS;

    // CORDIC unit
    localparam int CORDIC_N   = 16;
    localparam int CORDIC_LAT = CORDIC_N + 1;
    localparam int CIN_W      = 20;
    localparam int CW         = 60;
    localparam int ZW         = 33;
    localparam int SCALE_SH   = 56 - COORD_W;
    localparam int ANG_SH     = 15;

    localparam logic signed [ZW-1:0] PI_Q28     = 33'sd843314857;
    localparam logic signed [ZW-1:0] ROUND_HALF = 33'sd16384;
    localparam logic signed [ZW-1:0] PI_Q13     = 33'sd25736;
    localparam logic signed [ZW-1:0] HALF_PI_Q13 = 33'sd12868;

    // atan(2^-i) in Q4.28
    localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_N] = '{
        33'sd210828714, 33'sd124459457, 33'sd65760959, 33'sd33381290,
        33'sd16755422,  33'sd8385879,   33'sd4193963,  33'sd2097109,
        33'sd1048571,   33'sd524287,    33'sd262144,   33'sd131072,
        33'sd65536,     33'sd32768,     33'sd16384,    33'sd8192
    };

    // Pipeline depth
    localparam int FRONT_N = 3;
    localparam int AZ_DLY  = SQ_STEPS + 1;
    localparam int VLD_N   = FRONT_N + SQ_STEPS + 1 + CORDIC_LAT;

    typedef struct packed {
        logic [SQ_W-1:0] n;
        logic [SQ_W-1:0] r;
    } paik_sq_t;

    function automatic logic [SQ_W-1:0] sq_bit(input int k);
        return SQ_W'(1) << (SQ_TOP - 2 * k);
    endfunction

    // One step of the digit-by-digit square root
    function automatic paik_sq_t sqrt_step(input paik_sq_t a, input logic [SQ_W-1:0] bitv);
        paik_sq_t o;
        if (a.n >= a.r + bitv)
        begin
            o.n = a.n - (a.r + bitv);
            o.r = (a.r >> 1) + bitv;
        end
        else
        begin
            o.n = a.n;
            o.r = a.r >> 1;
        end
        return o;
    endfunction

endpackage

// ===== rtl/polar_arm_inverse_kinematics.sv =====
// Polar arm inverse kinematics.
// Input channel: in_valid / in_stall with target_x, target_y, target_z
// (signed Q5.12). A request is taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall with azimuth (Q2.13 rad), elevation
// (Q1.13 rad), radial_length (Q5.12) and status (0 ok, 1 too near, 2 too far,
// 3 elevation out of range); joint fields are zero on any error.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 column
// height, 1 minimum radius, 2 maximum radius); other indexes are ignored.
// Write only while no request is in flight.
// Pipeline: 41 register stages, the first loaded at the accepting edge:
// 3 front stages, 19 square root stages, 1 rounding stage, 17 CORDIC
// stages, output register.
// Throughput: one request per cycle while the output is not stalled; the
// square root and both CORDIC units are fully pipelined.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the register reset values
// (column height 4096, minimum 2048, maximum 8192).
module polar_arm_inverse_kinematics (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [paik_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [paik_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [paik_pkg::COORD_W-1:0]    target_x,
    input  logic signed [paik_pkg::COORD_W-1:0]    target_y,
    input  logic signed [paik_pkg::COORD_W-1:0]    target_z,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [paik_pkg::ANG_W-1:0]      azimuth,
    output logic signed [paik_pkg::ELEV_W-1:0]     elevation,
    output logic [paik_pkg::RAD_W-1:0]             radial_length,
    output logic [1:0]                             status
);

    logic en;

    logic [paik_pkg::CH_W-1:0]   column_height_reg;
    logic [paik_pkg::RMIN_W-1:0] rho_min_reg;
    logic [paik_pkg::RMAX_W-1:0] rho_max_reg;
    logic [paik_pkg::RMIN2_W-1:0] rmin2_reg;
    logic [paik_pkg::RMAX2_W-1:0] rmax2_reg;

    logic [paik_pkg::VLD_N-1:0] v_reg;

    logic signed [paik_pkg::COORD_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;
    logic signed [paik_pkg::ZR_W-1:0]    zr1_reg, zr2_reg, zr3_reg;
    logic signed [paik_pkg::SQP_W-1:0]   xx_prod, yy_prod;
    logic signed [paik_pkg::ZZP_W-1:0]   zz_prod;
    logic [paik_pkg::SQP_W-1:0]          xx2_reg, yy2_reg;
    logic [paik_pkg::ZZP_W-1:0]          zz2_reg;
    logic [paik_pkg::SXY_W-1:0]          sxy3_reg;
    logic [paik_pkg::S_W-1:0]            s3_reg;

    paik_pkg::paik_sq_t sxy_q_reg  [paik_pkg::SQ_STEPS];
    paik_pkg::paik_sq_t s_q_reg    [paik_pkg::SQ_STEPS];
    paik_pkg::paik_sq_t sxy_q_next [paik_pkg::SQ_STEPS];
    paik_pkg::paik_sq_t s_q_next   [paik_pkg::SQ_STEPS];
    logic signed [paik_pkg::ZR_W-1:0] sq_zr_reg [paik_pkg::SQ_STEPS];
    logic [paik_pkg::SQ_STEPS-1:0]    sq_near_reg, sq_far_reg;

    logic [paik_pkg::ROOT_W-1:0]      rd_rxy_reg, rd_rho_reg;
    logic signed [paik_pkg::ZR_W-1:0] rd_zr_reg;
    logic                             rd_near_reg, rd_far_reg;
    paik_pkg::paik_sq_t               sxy_last, s_last;

    logic [paik_pkg::CORDIC_LAT-1:0]  el_near_reg, el_far_reg;
    logic [paik_pkg::ROOT_W-1:0]      el_rho_reg [paik_pkg::CORDIC_LAT];
    logic signed [paik_pkg::ZW-1:0]   az_dly_reg [paik_pkg::AZ_DLY];

    logic signed [paik_pkg::ZW-1:0]   az_z, el_z, az_q, el_q;
    logic signed [paik_pkg::CIN_W-1:0] el_x_in;

    logic                              out_valid_reg;
    logic signed [paik_pkg::ANG_W-1:0] azimuth_reg, azimuth_next;
    logic signed [paik_pkg::ELEV_W-1:0] elevation_reg, elevation_next;
    logic [paik_pkg::RAD_W-1:0]        radial_length_reg, radial_length_next;
    logic [1:0]                        status_reg, status_next;

    // Hold the whole pipeline while a result waits at the output
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_height_reg <= 13'd4096;
            rho_min_reg       <= 13'd2048;
            rho_max_reg       <= 15'd8192;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                paik_pkg::CFG_COLUMN_HEIGHT: column_height_reg <= cfg_data[paik_pkg::CH_W-1:0];
                paik_pkg::CFG_RHO_MIN:       rho_min_reg       <= cfg_data[paik_pkg::RMIN_W-1:0];
                paik_pkg::CFG_RHO_MAX:       rho_max_reg       <= cfg_data[paik_pkg::RMAX_W-1:0];
                default:                     ;
            endcase
        end
    end

    // Square the radius limits
    always_ff @(posedge clk)
    begin
        rmin2_reg <= rho_min_reg * rho_min_reg;
        rmax2_reg <= rho_max_reg * rho_max_reg;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[paik_pkg::VLD_N-2:0], in_valid};
            out_valid_reg <= v_reg[paik_pkg::VLD_N-1];
        end
    end

    assign xx_prod = x1_reg * x1_reg;
    assign yy_prod = y1_reg * y1_reg;
    assign zz_prod = zr1_reg * zr1_reg;

    // Front stages: shoulder frame, squares, sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= target_x;
            y1_reg  <= target_y;
            zr1_reg <= paik_pkg::ZR_W'(target_z)
                       - paik_pkg::ZR_W'($signed({1'b0, column_height_reg}));
            x2_reg  <= x1_reg;
            y2_reg  <= y1_reg;
            zr2_reg <= zr1_reg;
            xx2_reg <= xx_prod;
            yy2_reg <= yy_prod;
            zz2_reg <= zz_prod;
            x3_reg  <= x2_reg;
            y3_reg  <= y2_reg;
            zr3_reg <= zr2_reg;
            sxy3_reg <= paik_pkg::SXY_W'(xx2_reg) + paik_pkg::SXY_W'(yy2_reg);
            s3_reg   <= paik_pkg::S_W'(xx2_reg) + paik_pkg::S_W'(yy2_reg)
                        + paik_pkg::S_W'(zz2_reg);
        end
    end

    // Square root steps, one root bit per stage
    always_comb
    begin
        sxy_q_next[0] = paik_pkg::sqrt_step('{n: paik_pkg::SQ_W'(sxy3_reg), r: '0},
                                            paik_pkg::sq_bit(0));
        s_q_next[0]   = paik_pkg::sqrt_step('{n: paik_pkg::SQ_W'(s3_reg), r: '0},
                                            paik_pkg::sq_bit(0));
        for (int k = 1; k < paik_pkg::SQ_STEPS; k++)
        begin
            sxy_q_next[k] = paik_pkg::sqrt_step(sxy_q_reg[k-1], paik_pkg::sq_bit(k));
            s_q_next[k]   = paik_pkg::sqrt_step(s_q_reg[k-1], paik_pkg::sq_bit(k));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < paik_pkg::SQ_STEPS; k++)
            begin
                sxy_q_reg[k] <= sxy_q_next[k];
                s_q_reg[k]   <= s_q_next[k];
            end
            sq_zr_reg[0] <= zr3_reg;
            for (int k = 1; k < paik_pkg::SQ_STEPS; k++)
                sq_zr_reg[k] <= sq_zr_reg[k-1];
            sq_near_reg <= {sq_near_reg[paik_pkg::SQ_STEPS-2:0],
                            s3_reg < paik_pkg::S_W'(rmin2_reg)};
            sq_far_reg  <= {sq_far_reg[paik_pkg::SQ_STEPS-2:0],
                            s3_reg > paik_pkg::S_W'(rmax2_reg)};
        end
    end

    // Round roots to nearest: bump when remainder exceeds root
    assign sxy_last = sxy_q_reg[paik_pkg::SQ_STEPS-1];
    assign s_last   = s_q_reg[paik_pkg::SQ_STEPS-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_rxy_reg  <= sxy_last.r[paik_pkg::ROOT_W-1:0]
                           + paik_pkg::ROOT_W'(sxy_last.n > sxy_last.r);
            rd_rho_reg  <= s_last.r[paik_pkg::ROOT_W-1:0]
                           + paik_pkg::ROOT_W'(s_last.n > s_last.r);
            rd_zr_reg   <= sq_zr_reg[paik_pkg::SQ_STEPS-1];
            rd_near_reg <= sq_near_reg[paik_pkg::SQ_STEPS-1];
            rd_far_reg  <= sq_far_reg[paik_pkg::SQ_STEPS-1];
        end
    end

    // Azimuth starts right after the front stages
    paik_cordic u_az_cordic (
        .clk   (clk),
        .en    (en),
        .y_in  (paik_pkg::CIN_W'(y3_reg)),
        .x_in  (paik_pkg::CIN_W'(x3_reg)),
        .z_out (az_z)
    );

    // Elevation waits for the planar radius
    assign el_x_in = $signed({1'b0, rd_rxy_reg});

    paik_cordic u_el_cordic (
        .clk   (clk),
        .en    (en),
        .y_in  (paik_pkg::CIN_W'(rd_zr_reg)),
        .x_in  (el_x_in),
        .z_out (el_z)
    );

    // Align azimuth and side data with the elevation result
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            az_dly_reg[0] <= az_z;
            for (int k = 1; k < paik_pkg::AZ_DLY; k++)
                az_dly_reg[k] <= az_dly_reg[k-1];
            el_rho_reg[0] <= rd_rho_reg;
            for (int k = 1; k < paik_pkg::CORDIC_LAT; k++)
                el_rho_reg[k] <= el_rho_reg[k-1];
            el_near_reg <= {el_near_reg[paik_pkg::CORDIC_LAT-2:0], rd_near_reg};
            el_far_reg  <= {el_far_reg[paik_pkg::CORDIC_LAT-2:0], rd_far_reg};
        end
    end

    // Round angles to Q2.13, classify, clamp and zero on error
    assign az_q = (az_dly_reg[paik_pkg::AZ_DLY-1] + paik_pkg::ROUND_HALF) >>> paik_pkg::ANG_SH;
    assign el_q = (el_z + paik_pkg::ROUND_HALF) >>> paik_pkg::ANG_SH;

    always_comb
    begin
        azimuth_next       = '0;
        elevation_next     = '0;
        radial_length_next = '0;
        priority if (el_near_reg[paik_pkg::CORDIC_LAT-1])
            status_next = paik_pkg::ST_NEAR;
        else if (el_far_reg[paik_pkg::CORDIC_LAT-1])
            status_next = paik_pkg::ST_FAR;
        else if (el_q > paik_pkg::HALF_PI_Q13 || el_q < -paik_pkg::HALF_PI_Q13)
            status_next = paik_pkg::ST_ELEV;
        else
        begin
            status_next    = paik_pkg::ST_OK;
            elevation_next = el_q[paik_pkg::ELEV_W-1:0];
            if (az_q > paik_pkg::PI_Q13)
                azimuth_next = paik_pkg::PI_Q13[paik_pkg::ANG_W-1:0];
            else if (az_q < -paik_pkg::PI_Q13)
                azimuth_next = paik_pkg::ANG_W'(-paik_pkg::PI_Q13);
            else
                azimuth_next = az_q[paik_pkg::ANG_W-1:0];
            if (el_rho_reg[paik_pkg::CORDIC_LAT-1] > paik_pkg::ROOT_W'({paik_pkg::RAD_W{1'b1}}))
                radial_length_next = '1;
            else
                radial_length_next = el_rho_reg[paik_pkg::CORDIC_LAT-1][paik_pkg::RAD_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            azimuth_reg       <= azimuth_next;
            elevation_reg     <= elevation_next;
            radial_length_reg <= radial_length_next;
            status_reg        <= status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign azimuth       = azimuth_reg;
    assign elevation     = elevation_reg;
    assign radial_length = radial_length_reg;
    assign status        = status_reg;

    // Error results carry zero joints
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != paik_pkg::ST_OK
            |-> azimuth == '0 && elevation == '0 && radial_length == '0)
        else $error("joint fields not cleared on error");

    // Reachable results keep elevation within a quarter turn
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == paik_pkg::ST_OK
            |-> elevation <= 15'sd12868 && elevation >= -15'sd12868)
        else $error("elevation out of range on reachable result");

    // Reachable results keep azimuth within a half turn
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == paik_pkg::ST_OK
            |-> azimuth <= 16'sd25736 && azimuth >= -16'sd25736)
        else $error("azimuth not clamped");

endmodule

// ===== rtl/paik_cordic.sv =====
module paik_cordic (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [paik_pkg::CIN_W-1:0]    y_in,
    input  logic signed [paik_pkg::CIN_W-1:0]    x_in,
    output logic signed [paik_pkg::ZW-1:0]       z_out
);

    logic signed [paik_pkg::CW-1:0] x_reg  [paik_pkg::CORDIC_N+1];
    logic signed [paik_pkg::CW-1:0] y_reg  [paik_pkg::CORDIC_N+1];
    logic signed [paik_pkg::ZW-1:0] z_reg  [paik_pkg::CORDIC_N+1];
    logic signed [paik_pkg::CW-1:0] x_next [paik_pkg::CORDIC_N+1];
    logic signed [paik_pkg::CW-1:0] y_next [paik_pkg::CORDIC_N+1];
    logic signed [paik_pkg::ZW-1:0] z_next [paik_pkg::CORDIC_N+1];
    logic signed [paik_pkg::CW-1:0] xe;
    logic signed [paik_pkg::CW-1:0] ye;

    // Scale up, fold the left half plane, then rotate toward the x axis
    always_comb
    begin
        xe = paik_pkg::CW'(x_in) <<< paik_pkg::SCALE_SH;
        ye = paik_pkg::CW'(y_in) <<< paik_pkg::SCALE_SH;
        if (x_in < 0)
        begin
            x_next[0] = -xe;
            y_next[0] = -ye;
            z_next[0] = (y_in >= 0) ? paik_pkg::PI_Q28 : -paik_pkg::PI_Q28;
        end
        else
        begin
            x_next[0] = xe;
            y_next[0] = ye;
            z_next[0] = '0;
        end
        for (int i = 0; i < paik_pkg::CORDIC_N; i++)
        begin
            if (y_reg[i] > 0)
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + paik_pkg::ATAN_TAB[i];
            end
            else if (y_reg[i] < 0)
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - paik_pkg::ATAN_TAB[i];
            end
            else
            begin
                x_next[i+1] = x_reg[i];
                y_next[i+1] = y_reg[i];
                z_next[i+1] = z_reg[i];
            end
        end
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= paik_pkg::CORDIC_N; i++)
            begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
            end
        end
    end

    assign z_out = z_reg[paik_pkg::CORDIC_N];

endmodule
